@@ hdl/bas_pkg.sv @@
`timescale 1ns / 1ps
`default_nettype none

package bas_pkg;

  localparam int SAMPLE_W = 24;
  localparam int RTO_W    = 24;

  // gain mode codes
  localparam logic [1:0] MODE_A128   = 2'd0;
  localparam logic [1:0] MODE_B32    = 2'd1;
  localparam logic [1:0] MODE_A64    = 2'd2;
  localparam logic [1:0] MODE_UNUSED = 2'd3;

  // result status codes
  localparam logic [1:0] ST_OK      = 2'd0;
  localparam logic [1:0] ST_TIMEOUT = 2'd1;
  localparam logic [1:0] ST_NOCLK   = 2'd2;
  localparam logic [1:0] ST_PDOWN   = 2'd3;

  typedef struct packed {
    logic [1:0]       gain_mode;
    logic [7:0]       high_ticks;
    logic [7:0]       low_ticks;
    logic [RTO_W-1:0] ready_timeout_ticks;
    logic [3:0]       settle_discards;
    logic             power_down;
  } cfg_t;

  typedef struct packed {
    logic [1:0]          status;
    logic [SAMPLE_W-1:0] sample;
    logic                done_res;
    logic                busy_res;
    logic                sclk_pin;
  } result_t;

  // extra pulses after the data bits select the next conversion's gain
  function automatic logic [1:0] extra_pulses(input logic [1:0] mode);
    logic [1:0] n;
    case (mode)
      MODE_B32: n = 2'd2;
      MODE_A64: n = 2'd3;
      default:  n = 2'd1;
    endcase
    return n;
  endfunction

endpackage

`default_nettype wire

@@ hdl/bas_regs.sv @@
`timescale 1ns / 1ps
`default_nettype none

module bas_regs (
  input  wire logic          clk,
  input  wire logic          rst,
  input  wire logic          psel,
  input  wire logic          penable,
  input  wire logic          pwrite,
  input  wire logic [4:0]    paddr,
  input  wire logic [31:0]   pwdata,
  output logic [31:0]        prdata,
  output logic               pready,
  output bas_pkg::cfg_t      cfg,
  output logic               av_clear
);

  localparam logic [2:0] REG_GAIN    = 3'd0;
  localparam logic [2:0] REG_HIGH    = 3'd1;
  localparam logic [2:0] REG_LOW     = 3'd2;
  localparam logic [2:0] REG_TIMEOUT = 3'd3;
  localparam logic [2:0] REG_SETTLE  = 3'd4;
  localparam logic [2:0] REG_PDOWN   = 3'd5;

  logic       wr;
  logic [2:0] idx;

  assign pready = 1'b1;
  assign idx    = paddr[4:2];
  assign wr     = psel & penable & pwrite;

  // a power-down write invalidates the applied gain mode
  assign av_clear = wr && (idx == REG_PDOWN) && pwdata[0];

  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.gain_mode           <= bas_pkg::MODE_A128;
      cfg.high_ticks          <= 8'd1;
      cfg.low_ticks           <= 8'd1;
      cfg.ready_timeout_ticks <= bas_pkg::RTO_W'(1000000);
      cfg.settle_discards     <= 4'd4;
      cfg.power_down          <= 1'b0;
    end else if (wr) begin
      case (idx)
        REG_GAIN:    cfg.gain_mode           <= pwdata[1:0];
        REG_HIGH:    cfg.high_ticks          <= pwdata[7:0];
        REG_LOW:     cfg.low_ticks           <= pwdata[7:0];
        REG_TIMEOUT: cfg.ready_timeout_ticks <= pwdata[bas_pkg::RTO_W-1:0];
        REG_SETTLE:  cfg.settle_discards     <= pwdata[3:0];
        REG_PDOWN:   cfg.power_down          <= pwdata[0];
        default: ;
      endcase
    end
  end

  always_comb begin
    case (idx)
      REG_GAIN:    prdata = {30'd0, cfg.gain_mode};
      REG_HIGH:    prdata = {24'd0, cfg.high_ticks};
      REG_LOW:     prdata = {24'd0, cfg.low_ticks};
      REG_TIMEOUT: prdata = 32'(cfg.ready_timeout_ticks);
      REG_SETTLE:  prdata = {28'd0, cfg.settle_discards};
      REG_PDOWN:   prdata = {31'd0, cfg.power_down};
      default:     prdata = 32'd0;
    endcase
  end

endmodule

`default_nettype wire

@@ hdl/bas_core.sv @@
`timescale 1ns / 1ps
`default_nettype none

module bas_core #(
  parameter int DATA_BITS     = 24,
  parameter int TIMEOUT_WIDTH = 24
) (
  input  wire logic           clk,
  input  wire logic           rst,
  input  wire logic           step,
  input  wire logic           data_pin,
  input  wire logic           start_req,
  input  wire bas_pkg::cfg_t  cfg,
  input  wire logic           av_clear,
  output bas_pkg::result_t    res
);

  localparam int CW = (TIMEOUT_WIDTH > bas_pkg::RTO_W) ? TIMEOUT_WIDTH : bas_pkg::RTO_W;
  localparam logic [TIMEOUT_WIDTH-1:0] WAIT_MAX = '1;

  typedef enum logic [1:0] {PH_IDLE, PH_WAIT, PH_HIGH, PH_LOW} phase_t;

  phase_t                   phase, phase_next;
  logic [7:0]               phase_ticks, phase_ticks_next;
  logic [4:0]               pulse_index, pulse_index_next;
  logic [DATA_BITS-1:0]     shift_bits, shift_bits_next;
  logic [TIMEOUT_WIDTH-1:0] wait_ticks, wait_ticks_next;
  logic [3:0]               discards_left, discards_left_next;
  logic [1:0]               applied_mode, applied_mode_next;
  logic                     applied_valid, applied_valid_next;

  logic [7:0]               hi, lo, pt_inc;
  logic [4:0]               pi_inc, pulses;
  logic [TIMEOUT_WIDTH-1:0] wait_inc;
  logic [CW-1:0]            lim_raw, lim;
  logic [1:0]               mode_sel;
  logic signed [DATA_BITS-1:0] raw_s;

  assign hi       = (cfg.high_ticks == 8'd0) ? 8'd1 : cfg.high_ticks;
  assign lo       = (cfg.low_ticks == 8'd0) ? 8'd1 : cfg.low_ticks;
  assign pt_inc   = phase_ticks + 8'd1;
  assign pi_inc   = pulse_index + 5'd1;
  assign pulses   = 5'(DATA_BITS) + {3'd0, bas_pkg::extra_pulses(applied_mode)};
  assign wait_inc = (wait_ticks == WAIT_MAX) ? wait_ticks : wait_ticks + 1'b1;
  assign lim_raw  = (cfg.ready_timeout_ticks == '0) ? CW'(1) : CW'(cfg.ready_timeout_ticks);
  assign lim      = (lim_raw > CW'(WAIT_MAX)) ? CW'(WAIT_MAX) : lim_raw;
  assign mode_sel = (cfg.gain_mode == bas_pkg::MODE_UNUSED) ? bas_pkg::MODE_A128
                                                            : cfg.gain_mode;
  assign raw_s    = shift_bits;

  always_comb begin
    phase_next         = phase;
    phase_ticks_next   = phase_ticks;
    pulse_index_next   = pulse_index;
    shift_bits_next    = shift_bits;
    wait_ticks_next    = wait_ticks;
    discards_left_next = discards_left;
    applied_mode_next  = applied_mode;
    applied_valid_next = applied_valid;
    res.done_res       = 1'b0;
    res.status         = bas_pkg::ST_OK;
    res.sample         = '0;

    if (cfg.power_down) begin
      phase_next         = PH_IDLE;
      applied_valid_next = 1'b0;
      if (start_req) begin
        res.done_res = 1'b1;
        res.status   = bas_pkg::ST_PDOWN;
      end
    end else begin
      case (phase)
        PH_IDLE: begin
          if (start_req) begin
            if (!applied_valid || (mode_sel != applied_mode)) begin
              discards_left_next = cfg.settle_discards;
            end
            applied_mode_next  = mode_sel;
            applied_valid_next = 1'b1;
            wait_ticks_next    = '0;
            phase_next         = PH_WAIT;
          end
        end
        PH_WAIT: begin
          if (!data_pin) begin
            phase_next       = PH_HIGH;
            phase_ticks_next = 8'd0;
            pulse_index_next = 5'd0;
            shift_bits_next  = '0;
          end else begin
            wait_ticks_next = wait_inc;
            if (CW'(wait_inc) >= lim) begin
              res.done_res = 1'b1;
              res.status   = bas_pkg::ST_TIMEOUT;
              phase_next   = PH_IDLE;
              if (discards_left != 4'd0) applied_valid_next = 1'b0;
            end
          end
        end
        PH_HIGH: begin
          phase_ticks_next = pt_inc;
          if (pt_inc >= hi) begin
            // sample at the end of the high phase, MSB first
            if (pulse_index < 5'(DATA_BITS)) begin
              shift_bits_next = {shift_bits[DATA_BITS-2:0], data_pin};
            end
            phase_next       = PH_LOW;
            phase_ticks_next = 8'd0;
          end
        end
        PH_LOW: begin
          phase_ticks_next = pt_inc;
          if (pt_inc >= lo) begin
            phase_ticks_next = 8'd0;
            pulse_index_next = pi_inc;
            if (pi_inc >= pulses) begin
              if (!data_pin) begin
                res.done_res = 1'b1;
                res.status   = bas_pkg::ST_NOCLK;
                phase_next   = PH_IDLE;
                if (discards_left != 4'd0) applied_valid_next = 1'b0;
              end else if (discards_left != 4'd0) begin
                discards_left_next = discards_left - 4'd1;
                wait_ticks_next    = '0;
                phase_next         = PH_WAIT;
              end else begin
                res.done_res = 1'b1;
                res.status   = bas_pkg::ST_OK;
                res.sample   = bas_pkg::SAMPLE_W'(raw_s);
                phase_next   = PH_IDLE;
              end
            end else begin
              phase_next = PH_HIGH;
            end
          end
        end
        default: phase_next = PH_IDLE;
      endcase
    end

    res.sclk_pin = cfg.power_down || (phase_next == PH_HIGH);
    res.busy_res = (phase_next != PH_IDLE);
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      phase         <= PH_IDLE;
      phase_ticks   <= 8'd0;
      pulse_index   <= 5'd0;
      shift_bits    <= '0;
      wait_ticks    <= '0;
      discards_left <= 4'd0;
      applied_mode  <= bas_pkg::MODE_A128;
      applied_valid <= 1'b0;
    end else begin
      if (step) begin
        phase         <= phase_next;
        phase_ticks   <= phase_ticks_next;
        pulse_index   <= pulse_index_next;
        shift_bits    <= shift_bits_next;
        wait_ticks    <= wait_ticks_next;
        discards_left <= discards_left_next;
        applied_mode  <= applied_mode_next;
      end
      if (av_clear) begin
        applied_valid <= 1'b0;
      end else if (step) begin
        applied_valid <= applied_valid_next;
      end
    end
  end

endmodule

`default_nettype wire

@@ hdl/bridge_adc_serial_reader.sv @@
`timescale 1ns / 1ps
`default_nettype none

// Channel   Dir  Beat contents
// s_axis    in   one timebase tick: data-line level and start request
// m_axis    out  one status beat per tick: clock level, busy, done, sample, status
// apb       in   gain, pulse timing, ready timeout, settle discards, power-down
//
// Every input beat yields exactly one output beat. The tick's state update and
// its result are computed in one pass of combinational logic from the state
// registers and land in the output register on the accept edge, so a beat can
// be taken every cycle. s_tready drops only while the output register holds a
// beat that m_tready refuses; the state then holds. rst (synchronous) returns
// the sequencer to idle and restores the register defaults.
module bridge_adc_serial_reader #(
  parameter int DATA_BITS     = 24,
  parameter int TIMEOUT_WIDTH = 24
) (
  input  wire logic        clk,
  input  wire logic        rst,
  // stream in
  input  wire logic        s_tvalid,
  output logic             s_tready,
  input  wire logic [7:0]  s_tdata,   // [0] data_pin, [1] start_req, [7:2] zero
  // stream out
  output logic             m_tvalid,
  input  wire logic        m_tready,
  output logic [31:0]      m_tdata,   // [0] sclk_pin, [1] busy_res, [2] done_res,
                                      // [26:3] sample, [28:27] status, [31:29] zero
  // configuration
  input  wire logic        psel,
  input  wire logic        penable,
  input  wire logic        pwrite,
  input  wire logic [4:0]  paddr,
  input  wire logic [31:0] pwdata,
  output logic [31:0]      prdata,
  output logic             pready
);

  bas_pkg::cfg_t    cfg;
  bas_pkg::result_t res;
  logic             av_clear;
  logic             step;
  logic             out_valid;
  bas_pkg::result_t out_res;

  // advance on every accepted tick; hold while the result register is stuck
  assign s_tready = !out_valid || m_tready;
  assign step     = s_tvalid && s_tready;

  bas_regs u_regs (
    .clk      (clk),
    .rst      (rst),
    .psel     (psel),
    .penable  (penable),
    .pwrite   (pwrite),
    .paddr    (paddr),
    .pwdata   (pwdata),
    .prdata   (prdata),
    .pready   (pready),
    .cfg      (cfg),
    .av_clear (av_clear)
  );

  bas_core #(
    .DATA_BITS     (DATA_BITS),
    .TIMEOUT_WIDTH (TIMEOUT_WIDTH)
  ) u_core (
    .clk        (clk),
    .rst        (rst),
    .step       (step),
    .data_pin   (s_tdata[0]),
    .start_req  (s_tdata[1]),
    .cfg        (cfg),
    .av_clear   (av_clear),
    .res        (res)
  );

  // output register: load on accept, drop the valid once the beat is taken
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (step) begin
      out_valid <= 1'b1;
    end else if (m_tready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (step) begin
      out_res <= res;
    end
  end

  assign m_tvalid = out_valid;
  assign m_tdata  = {3'd0, out_res.status, out_res.sample, out_res.done_res,
                     out_res.busy_res, out_res.sclk_pin};

endmodule

`default_nettype wire

@@ tb/sv/tb.sv @@
`timescale 1ns / 1ps

module tb;

  // Register map, one 32-bit word per register
  localparam int REG_GAIN_MODE  = 0;
  localparam int REG_HIGH_TICKS = 1;
  localparam int REG_LOW_TICKS  = 2;
  localparam int REG_TIMEOUT    = 3;
  localparam int REG_SETTLE     = 4;
  localparam int REG_POWER_DOWN = 5;

  // Input beats to send in all; the random part stops once this is reached
  localparam int ITEM_GOAL = 640;

  typedef enum logic [2:0] {RD_IDLE, RD_WAIT, RD_HIGH, RD_LOW} rd_phase_t;
  typedef enum logic [1:0] {ROW_TICK, ROW_REG, ROW_CONV} row_kind_t;

  // Status beats that can be written down without working through the sequencer.
  // Field order: status, sample, done_res, busy_res, sclk_pin.
  localparam bas_pkg::result_t RES_IDLE     = '{bas_pkg::ST_OK,      24'd0, 1'b0, 1'b0, 1'b0};
  localparam bas_pkg::result_t RES_WAIT     = '{bas_pkg::ST_OK,      24'd0, 1'b0, 1'b1, 1'b0};
  localparam bas_pkg::result_t RES_TIMEOUT  = '{bas_pkg::ST_TIMEOUT, 24'd0, 1'b1, 1'b0, 1'b0};
  localparam bas_pkg::result_t RES_PDOWN    = '{bas_pkg::ST_PDOWN,   24'd0, 1'b1, 1'b0, 1'b1};
  localparam bas_pkg::result_t RES_PD_QUIET = '{bas_pkg::ST_OK,      24'd0, 1'b0, 1'b0, 1'b1};

  typedef struct packed {
    row_kind_t        kind;
    int               arg;    // register index, or ready delay in ticks for a conversion
    logic [31:0]      value;  // register value, or the converter's data word
    logic             dout;   // tick level, or level after the last pulse
    logic             start;
    logic             fixed;  // want holds the exact beat
    bas_pkg::result_t want;
  } plan_row_t;

  logic        clk;
  logic        rst;
  logic        s_tvalid;
  logic        s_tready;
  logic [7:0]  s_tdata;   // [0] data_pin, [1] start_req, [7:2] zero
  logic        m_tvalid;
  logic        m_tready;
  logic [31:0] m_tdata;   // [0] sclk_pin, [1] busy_res, [2] done_res,
                          // [26:3] sample, [28:27] status, [31:29] zero
  logic        psel;
  logic        penable;
  logic        pwrite;
  logic [4:0]  paddr;
  logic [31:0] pwdata;
  logic [31:0] prdata;
  logic        pready;

  bridge_adc_serial_reader u_dut (
    .clk      (clk),
    .rst      (rst),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .s_tdata  (s_tdata),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata),
    .psel     (psel),
    .penable  (penable),
    .pwrite   (pwrite),
    .paddr    (paddr),
    .pwdata   (pwdata),
    .prdata   (prdata),
    .pready   (pready)
  );

  // Register image and sequencer state, both at their reset values
  bas_pkg::cfg_t cfg = '{bas_pkg::MODE_A128, 8'd1, 8'd1, 24'd1000000, 4'd4, 1'b0};
  rd_phase_t   rd_phase    = RD_IDLE;
  logic [7:0]  rd_ticks    = '0;
  logic [4:0]  rd_pulse    = '0;
  logic [23:0] rd_shift    = '0;
  logic [23:0] rd_wait     = '0;
  logic [3:0]  rd_discards = '0;
  logic [1:0]  rd_mode     = bas_pkg::MODE_A128;
  logic        rd_armed    = 1'b0;

  bas_pkg::result_t status_beats_due [$];
  int      readings_reported = 0;
  int      items_sent = 0;
  int      errors = 0;
  int      idle_pct = 24;

  // Directed part: quiet ticks after reset, the zero-means-one counts, a start
  // ignored while busy, power-down refusal, each gain mode and the unused one,
  // full-scale samples, timeout and missing-clock errors, settling after a mode
  // change and an error hit while still settling.
  plan_row_t plan [26] = '{
    '{ROW_TICK, 0,              32'd0,       1'b1, 1'b0, 1'b1, RES_IDLE},
    '{ROW_TICK, 0,              32'd0,       1'b0, 1'b0, 1'b1, RES_IDLE},
    '{ROW_REG,  REG_TIMEOUT,    32'd0,       1'b0, 1'b0, 1'b0, RES_IDLE},
    '{ROW_TICK, 0,              32'd0,       1'b1, 1'b1, 1'b1, RES_WAIT},
    '{ROW_TICK, 0,              32'd0,       1'b1, 1'b1, 1'b1, RES_TIMEOUT},
    '{ROW_REG,  REG_POWER_DOWN, 32'd1,       1'b0, 1'b0, 1'b0, RES_IDLE},
    '{ROW_TICK, 0,              32'd0,       1'b0, 1'b1, 1'b1, RES_PDOWN},
    '{ROW_TICK, 0,              32'd0,       1'b1, 1'b0, 1'b1, RES_PD_QUIET},
    '{ROW_REG,  REG_POWER_DOWN, 32'd0,       1'b0, 1'b0, 1'b0, RES_IDLE},
    '{ROW_REG,  REG_SETTLE,     32'd0,       1'b0, 1'b0, 1'b0, RES_IDLE},
    '{ROW_REG,  REG_TIMEOUT,    32'd3,       1'b0, 1'b0, 1'b0, RES_IDLE},
    '{ROW_REG,  REG_HIGH_TICKS, 32'd0,       1'b0, 1'b0, 1'b0, RES_IDLE},
    '{ROW_REG,  REG_LOW_TICKS,  32'd0,       1'b0, 1'b0, 1'b0, RES_IDLE},
    '{ROW_REG,  REG_GAIN_MODE,  32'(bas_pkg::MODE_UNUSED), 1'b0, 1'b0, 1'b0, RES_IDLE},
    '{ROW_CONV, 0,              32'h7FFFFF,  1'b1, 1'b0, 1'b0, RES_IDLE},
    '{ROW_CONV, 2,              32'h800000,  1'b1, 1'b0, 1'b0, RES_IDLE},
    '{ROW_REG,  REG_GAIN_MODE,  32'(bas_pkg::MODE_B32),    1'b0, 1'b0, 1'b0, RES_IDLE},
    '{ROW_CONV, 1,              32'h000000,  1'b1, 1'b0, 1'b0, RES_IDLE},
    '{ROW_CONV, 3,              32'hFFFFFF,  1'b1, 1'b0, 1'b0, RES_IDLE},
    '{ROW_CONV, 0,              32'hFFFFFF,  1'b0, 1'b0, 1'b0, RES_IDLE},
    '{ROW_REG,  REG_GAIN_MODE,  32'(bas_pkg::MODE_A64),    1'b0, 1'b0, 1'b0, RES_IDLE},
    '{ROW_REG,  REG_SETTLE,     32'd1,       1'b0, 1'b0, 1'b0, RES_IDLE},
    '{ROW_CONV, 0,              32'hA5A5A5,  1'b1, 1'b0, 1'b0, RES_IDLE},
    '{ROW_REG,  REG_GAIN_MODE,  32'(bas_pkg::MODE_A128),   1'b0, 1'b0, 1'b0, RES_IDLE},
    '{ROW_CONV, 0,              32'h5A5A5A,  1'b0, 1'b0, 1'b0, RES_IDLE},
    '{ROW_CONV, 1,              32'h123456,  1'b1, 1'b0, 1'b0, RES_IDLE}
  };

  initial begin
    clk = 1'b0;
    forever #4 clk = ~clk;
  end

  // Hard stop in case a handshake never completes
  initial begin
    #1_000_000;
    $display("DONE: errors detected");
    $finish;
  end

  // Output side backpressure, same idle share as the input side
  always @(negedge clk) m_tready <= ($urandom_range(99) >= idle_pct);

  function automatic int pulses_for(input logic [1:0] mode);
    case (mode)
      bas_pkg::MODE_B32: return 26;
      bas_pkg::MODE_A64: return 27;
      default:           return 25;
    endcase
  endfunction

  // Advance the sequencer by one tick and form its status beat
  task automatic advance_reader(input logic dout, input logic start,
                                output bas_pkg::result_t r);
    logic [7:0]  hi_eff;
    logic [7:0]  lo_eff;
    logic [23:0] lim;
    logic [1:0]  mode;
    r = '0;
    hi_eff = (cfg.high_ticks == 0) ? 8'd1 : cfg.high_ticks;
    lo_eff = (cfg.low_ticks == 0) ? 8'd1 : cfg.low_ticks;
    if (cfg.power_down) begin
      // abandon whatever runs and force settling on the next start
      rd_phase = RD_IDLE;
      rd_armed = 1'b0;
      if (start) begin
        r.done_res = 1'b1;
        r.status   = bas_pkg::ST_PDOWN;
      end
    end else begin
      case (rd_phase)
        RD_IDLE: begin
          if (start) begin
            mode = (cfg.gain_mode == bas_pkg::MODE_UNUSED) ? bas_pkg::MODE_A128
                                                           : cfg.gain_mode;
            if (!rd_armed || mode != rd_mode) rd_discards = cfg.settle_discards;
            rd_mode  = mode;
            rd_armed = 1'b1;
            rd_wait  = '0;
            rd_phase = RD_WAIT;
          end
        end
        RD_WAIT: begin
          if (!dout) begin
            rd_phase = RD_HIGH;
            rd_ticks = '0;
            rd_pulse = '0;
            rd_shift = '0;
          end else begin
            // timeout register is as wide as the counter, so no clamp needed
            lim = (cfg.ready_timeout_ticks == 0) ? 24'd1 : cfg.ready_timeout_ticks;
            if (rd_wait != '1) rd_wait = rd_wait + 24'd1;
            if (rd_wait >= lim) begin
              r.done_res = 1'b1;
              r.status   = bas_pkg::ST_TIMEOUT;
              rd_phase   = RD_IDLE;
              if (rd_discards != 0) rd_armed = 1'b0;
            end
          end
        end
        RD_HIGH: begin
          rd_ticks = rd_ticks + 8'd1;
          if (rd_ticks >= hi_eff) begin
            if (rd_pulse < 24) rd_shift = {rd_shift[22:0], dout};
            rd_phase = RD_LOW;
            rd_ticks = '0;
          end
        end
        default: begin
          rd_ticks = rd_ticks + 8'd1;
          if (rd_ticks >= lo_eff) begin
            rd_ticks = '0;
            rd_pulse = rd_pulse + 5'd1;
            if (rd_pulse >= pulses_for(rd_mode)) begin
              if (!dout) begin
                r.done_res = 1'b1;
                r.status   = bas_pkg::ST_NOCLK;
                rd_phase   = RD_IDLE;
                if (rd_discards != 0) rd_armed = 1'b0;
              end else if (rd_discards != 0) begin
                rd_discards = rd_discards - 4'd1;
                rd_wait     = '0;
                rd_phase    = RD_WAIT;
              end else begin
                r.done_res = 1'b1;
                r.sample   = rd_shift;
                rd_phase   = RD_IDLE;
              end
            end else begin
              rd_phase = RD_HIGH;
            end
          end
        end
      endcase
    end
    r.sclk_pin = cfg.power_down || rd_phase == RD_HIGH;
    r.busy_res = rd_phase != RD_IDLE;
  endtask

  // Offer one tick beat, hold it until taken, then queue the status beat due
  task automatic send_tick(input logic dout, input logic start,
                           input logic fixed = 1'b0,
                           input bas_pkg::result_t want = '0);
    bas_pkg::result_t r;
    while (idle_pct != 0 && $urandom_range(99) < idle_pct) begin
      @(negedge clk);
      s_tvalid <= 1'b0;
    end
    @(negedge clk);
    s_tvalid <= 1'b1;
    s_tdata  <= {6'd0, start, dout};
    do @(posedge clk); while (!s_tready);
    items_sent++;
    advance_reader(dout, start, r);
    if (r.done_res) readings_reported++;
    status_beats_due.push_back(fixed ? want : r);
  endtask

  // Drop valid and let every due status beat come out before touching a register
  task automatic drain();
    @(negedge clk);
    s_tvalid <= 1'b0;
    while (status_beats_due.size() != 0) @(posedge clk);
    repeat (2) @(posedge clk);
  endtask

  task automatic write_reg(input int idx, input logic [31:0] value);
    @(negedge clk);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b1;
    paddr   <= 5'(idx * 4);
    pwdata  <= value;
    @(negedge clk);
    penable <= 1'b1;
    do @(posedge clk); while (!pready);
    case (idx)
      REG_GAIN_MODE:  cfg.gain_mode           = value[1:0];
      REG_HIGH_TICKS: cfg.high_ticks          = value[7:0];
      REG_LOW_TICKS:  cfg.low_ticks           = value[7:0];
      REG_TIMEOUT:    cfg.ready_timeout_ticks = value[23:0];
      REG_SETTLE:     cfg.settle_discards     = value[3:0];
      REG_POWER_DOWN: begin
        cfg.power_down = value[0];
        if (value[0]) rd_armed = 1'b0;
      end
      default: ;
    endcase
    @(negedge clk);
    psel    <= 1'b0;
    penable <= 1'b0;
  endtask

  // Play the converter side of one reading: start, hold the data line high for
  // `delay` waiting ticks, then serve `word` MSB first on the high phases and
  // `end_level` on the last tick of the final low phase. Stray starts ride along
  // and must be ignored. max_ticks of zero runs until the sequencer is idle.
  task automatic run_conversion(input logic [23:0] word, input int delay,
                                input logic end_level, input int max_ticks);
    int     n;
    logic   d;
    logic   last;
    logic [7:0] lo_eff;
    n = 0;
    send_tick(1'($urandom_range(1)), 1'b1);
    while (rd_phase != RD_IDLE && (max_ticks == 0 || n < max_ticks)) begin
      lo_eff = (cfg.low_ticks == 0) ? 8'd1 : cfg.low_ticks;
      case (rd_phase)
        RD_WAIT: d = (rd_wait < delay);
        RD_HIGH: d = (rd_pulse < 24) ? word[23 - rd_pulse] : 1'b1;
        default: begin
          last = (rd_pulse + 1 >= pulses_for(rd_mode)) && (rd_ticks + 1 >= lo_eff);
          d = last ? end_level : 1'($urandom_range(1));
        end
      endcase
      send_tick(d, $urandom_range(15) == 0);
      n++;
    end
  endtask

  function automatic logic [23:0] pick_word();
    case ($urandom_range(9))
      0:       return 24'h7FFFFF;
      1:       return 24'h800000;
      2:       return 24'h000000;
      3:       return 24'hFFFFFF;
      default: return 24'($urandom);
    endcase
  endfunction

  function automatic int pick_delay();
    int lim;
    lim = (cfg.ready_timeout_ticks == 0) ? 1 : int'(cfg.ready_timeout_ticks);
    // push past the timeout now and then, when the timeout is short enough
    if (lim <= 40 && $urandom_range(99) < 12) return lim + int'($urandom_range(2));
    return int'($urandom_range((lim > 30) ? 30 : lim - 1));
  endfunction

  task automatic note_mismatch(input string what, input logic [31:0] want,
                               input logic [31:0] got);
    errors++;
    if (errors <= 10)
      $display("%0t: %s mismatch, expected %h, got %h", $time, what, want, got);
  endtask

  // Check each status beat taken from the output against the oldest one due
  always @(posedge clk) begin : check_beats
    bas_pkg::result_t got;
    bas_pkg::result_t due;
    if (!rst && m_tvalid && m_tready) begin
      got = m_tdata[28:0];
      if (status_beats_due.size() == 0) begin
        note_mismatch("unexpected beat", 32'd0, m_tdata);
      end else begin
        due = status_beats_due.pop_front();
        if (got.sclk_pin !== due.sclk_pin)
          note_mismatch("sclk_pin", 32'(due.sclk_pin), 32'(got.sclk_pin));
        if (got.busy_res !== due.busy_res)
          note_mismatch("busy_res", 32'(due.busy_res), 32'(got.busy_res));
        if (got.done_res !== due.done_res)
          note_mismatch("done_res", 32'(due.done_res), 32'(got.done_res));
        if (got.sample !== due.sample)
          note_mismatch("sample", 32'(due.sample), 32'(got.sample));
        if (got.status !== due.status)
          note_mismatch("status", 32'(due.status), 32'(got.status));
      end
    end
  end

  initial begin : main
    int goal;
    int pick;
    logic [7:0] hi_val;
    logic [7:0] lo_val;

    rst      = 1'b1;
    s_tvalid = 1'b0;
    s_tdata  = '0;
    m_tready = 1'b0;
    psel     = 1'b0;
    penable  = 1'b0;
    pwrite   = 1'b0;
    paddr    = '0;
    pwdata   = '0;
    repeat (6) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;

    // Walk the directed table
    foreach (plan[i]) begin
      case (plan[i].kind)
        ROW_TICK: send_tick(plan[i].dout, plan[i].start, plan[i].fixed, plan[i].want);
        ROW_REG: begin
          drain();
          write_reg(plan[i].arg, plan[i].value);
        end
        default: run_conversion(plan[i].value[23:0], plan[i].arg, plan[i].dout, 0);
      endcase
    end

    // Random phases, each with its own register setting, until the beat budget
    // is spent. Phase 0 runs without any idling, phase 1 uses zero counts and
    // phase 2 the longest timeout.
    for (int ph = 0; ph < 12 && items_sent < ITEM_GOAL; ph++) begin
      drain();
      idle_pct = (ph == 0) ? 0 : 24;
      hi_val = (ph == 1) ? 8'd0 : 8'($urandom_range(1, 2));
      lo_val = (ph == 1) ? 8'd0 : 8'($urandom_range(1, 2));
      write_reg(REG_GAIN_MODE, 32'($urandom_range(3)));
      write_reg(REG_HIGH_TICKS, {24'd0, hi_val});
      write_reg(REG_LOW_TICKS, {24'd0, lo_val});
      write_reg(REG_TIMEOUT, (ph == 2) ? 32'hFFFFFF : 32'($urandom_range(0, 30)));
      write_reg(REG_SETTLE, 32'($urandom_range(0, 1)));
      write_reg(REG_POWER_DOWN, 32'd0);
      goal = readings_reported + 1;
      while (readings_reported < goal && items_sent < ITEM_GOAL) begin
        pick = int'($urandom_range(99));
        if (pick < 8) begin
          // raw noise on both lines
          repeat ($urandom_range(1, 6))
            send_tick(1'($urandom_range(1)), 1'($urandom_range(1)));
        end else if (pick < 12) begin
          // power down part way into a reading, knock on it, then power up
          run_conversion(pick_word(), pick_delay(), 1'b1, int'($urandom_range(1, 40)));
          drain();
          write_reg(REG_POWER_DOWN, 32'd1);
          repeat ($urandom_range(1, 4))
            send_tick(1'($urandom_range(1)), 1'($urandom_range(1)));
          drain();
          write_reg(REG_POWER_DOWN, 32'd0);
        end else begin
          run_conversion(pick_word(), pick_delay(), $urandom_range(99) >= 10, 0);
        end
      end
    end

    // Let the last status beats out, then a few more cycles for stray beats
    @(negedge clk);
    s_tvalid <= 1'b0;
    idle_pct = 24;
    while (status_beats_due.size() != 0) @(posedge clk);
    repeat (20) @(posedge clk);
    if (errors == 0) begin
      $display("DONE: 0 errors");
    end else begin
      $display("DONE: errors detected");
    end
    $finish;
  end

endmodule
